>>> sv/tag_value_jar_table_top_assert.svh
// Assertion macros for the tag/value table.
// Used by tag_value_jar_table_top; needs signals named clock and reset in scope.
`ifndef TAG_VALUE_JAR_TABLE_TOP_ASSERT_SVH
`define TAG_VALUE_JAR_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TVJT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define TVJT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TVJT_ASSERT_IMP(lbl, ante, cons, msg)
`define TVJT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/tvjt_pkg.sv
// Shared constants, codes and control/status structs of the tag/value table.
// No dependencies.
package tvjt_pkg;

   localparam int MAX_ENTRIES = 128;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int TAG_W       = 32;
   localparam int ENTRY_W     = 2 * TAG_W;
   localparam int TOTAL_W     = 8;
   localparam int CMP_W       = ((CNT_W > TOTAL_W) ? CNT_W : TOTAL_W) + 1;
   localparam int SLOT_W      = 16;
   localparam int REQ_W       = 72;
   localparam int RSP_W       = 40;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 8'd129;

   localparam logic [1:0] OP_GET = 2'd0;
   localparam logic [1:0] OP_SET = 2'd1;
   localparam logic [1:0] OP_DEL = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef enum logic [2:0] {
      RES_OK_ZERO,
      RES_TOTAL,
      RES_SLOT_TAG,
      RES_VALUE,
      RES_INVALID,
      RES_NOTFOUND,
      RES_FULL
   } res_type;

   typedef struct packed {
      logic    load_req;
      logic    scan_start;
      logic    scan_step;
      logic    shift_start;
      logic    shift_step;
      logic    hit_write;
      logic    append;
      logic    count_dec;
      logic    res_load;
      res_type res_code;
      logic    rsp_push;
   } cmd_type;

   typedef struct packed {
      logic [1:0]       opcode;
      logic             tag_zero;
      logic             tag_high_zero;
      logic             slot_bad;
      logic             slot_in;
      logic             zero_byte;
      logic             room;
      logic             hit;
      logic             scan_done;
      logic             rsp_free;
      logic [CNT_W-1:0] entry_count;
   } stat_type;

endpackage

>>> sv/tag_value_jar_table_top.sv
// Tag/value table, top level: ties the controller to the datapath.
// Uses tvjt_pkg, tvjt_ctrl, tvjt_dp and the assertion macro header.
//
// Usage:
//   req_* carries one request per item: opcode (get, set, delete), tag, value.
//   rsp_* returns exactly one item per request: status and data, in order.
//   csr_* writes total_slots (slots including the terminator); always ready,
//   to be written only while no request is in flight.
// Timing: one request at a time. Entries are scanned one per cycle from the
//   entry RAM (one read port, registered read). A delete stops its scan at the
//   hit and then moves each later entry down one per cycle.
// Reset (synchronous): table empty, total_slots back to 129, no item pending.
// A result waits in the output register while rsp_tready is low; the next
//   request is still taken and worked on, and only its own result waits for
//   the register to drain.
module tag_value_jar_table_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [tvjt_pkg::REQ_W-1:0]   req_tdata,   // opcode[1:0], tag[33:2], value[65:34]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [tvjt_pkg::RSP_W-1:0]   rsp_tdata,   // status[1:0], data[33:2]
   input  logic                         csr_tvalid,
   output logic                         csr_tready,
   input  logic [tvjt_pkg::TOTAL_W-1:0] csr_tdata    // total_slots[7:0]
);
   import tvjt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_tready = 1'b1;

   tvjt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tvjt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid & csr_tready),
      .csr_tdata  (csr_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

`include "tag_value_jar_table_top_assert.svh"

   `TVJT_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "item taken while busy")
   `TVJT_ASSERT_IMP(a_append_room, cmd.append, stat.room, "append without room")
   `TVJT_ASSERT_IMP(a_dec_nonempty, cmd.count_dec, stat.entry_count != '0, "delete from empty table")

endmodule

>>> sv/tvjt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tvjt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/tvjt_dp.sv
// Datapath of the tag/value table: request, count and config registers,
// entry RAM, scan/shift index, result and response registers. Uses tvjt_pkg, tvjt_ram.
module tvjt_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [tvjt_pkg::REQ_W-1:0]   req_tdata,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [tvjt_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                         csr_tvalid,
   input  logic [tvjt_pkg::TOTAL_W-1:0] csr_tdata,
   input  tvjt_pkg::cmd_type            cmd,
   output tvjt_pkg::stat_type           stat
);
   import tvjt_pkg::*;

   logic [1:0]         op_ff, op_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [TAG_W-1:0]   val_ff, val_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pidx_ff, pidx_in;
   logic [1:0]         res_st_ff, res_st_in;
   logic [TAG_W-1:0]   res_data_ff, res_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_st_ff, rsp_st_in;
   logic [TAG_W-1:0]   rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [IDX_W-1:0]   slot_addr;
   logic               step;
   logic               more;

   tvjt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entry word: value in the upper half, tag in the lower half
   assign slot_addr = IDX_W'(tag_ff[SLOT_W-1:0] - SLOT_W'(1));
   assign step      = cmd.scan_step | cmd.shift_step;
   assign more      = (idx_ff < count_ff);
   assign rd_addr   = step ? idx_ff[IDX_W-1:0] : slot_addr;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pidx_ff;
      wr_data = {val_ff, tag_ff};
      if (cmd.hit_write) begin
         wr_en = 1'b1;
      end else if (cmd.append) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
      end else if (cmd.shift_step && pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pidx_ff - IDX_W'(1);
         wr_data = rd_data;
      end
   end

   always_comb begin
      op_in        = op_ff;
      tag_in       = tag_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      res_st_in    = res_st_ff;
      res_data_in  = res_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_tvalid) begin
         total_in = csr_tdata;
      end
      if (cmd.load_req) begin
         op_in  = req_tdata[1:0];
         tag_in = req_tdata[TAG_W+1:2];
         val_in = req_tdata[2*TAG_W+1:TAG_W+2];
      end

      if (cmd.scan_start) begin
         idx_in  = '0;
         pend_in = 1'b0;
      end else if (cmd.shift_start) begin
         idx_in  = CNT_W'(pidx_ff) + CNT_W'(1);
         pend_in = 1'b0;
      end else if (step) begin
         pend_in = more;
         if (more) begin
            pidx_in = idx_ff[IDX_W-1:0];
            idx_in  = idx_ff + CNT_W'(1);
         end
      end

      if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.res_load) begin
         res_data_in = '0;
         unique case (cmd.res_code)
            RES_OK_ZERO:  res_st_in = ST_OK;
            RES_TOTAL: begin
               res_st_in   = ST_OK;
               res_data_in = TAG_W'(total_ff);
            end
            RES_SLOT_TAG: begin
               res_st_in   = ST_OK;
               res_data_in = rd_data[TAG_W-1:0];
            end
            RES_VALUE: begin
               res_st_in   = ST_OK;
               res_data_in = rd_data[ENTRY_W-1:TAG_W];
            end
            RES_INVALID:  res_st_in = ST_INVALID;
            RES_NOTFOUND: res_st_in = ST_NOTFOUND;
            RES_FULL:     res_st_in = ST_FULL;
            default:      res_st_in = ST_INVALID;
         endcase
      end

      if (cmd.rsp_push) begin
         rsp_valid_in = 1'b1;
         rsp_st_in    = res_st_ff;
         rsp_data_in  = res_data_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= TOTAL_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         total_ff     <= total_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      tag_ff      <= tag_in;
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      pidx_ff     <= pidx_in;
      res_st_ff   <= res_st_in;
      res_data_ff <= res_data_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      stat.opcode        = op_ff;
      stat.tag_zero      = (tag_ff == '0);
      stat.tag_high_zero = (tag_ff[TAG_W-1:SLOT_W] == '0);
      stat.slot_bad      = ((SLOT_W+1)'(tag_ff[SLOT_W-1:0]) >
                            (SLOT_W+1)'(count_ff) + (SLOT_W+1)'(1));
      stat.slot_in       = (tag_ff[SLOT_W-1:0] <= SLOT_W'(count_ff));
      stat.zero_byte     = (tag_ff[31:24] == '0) || (tag_ff[23:16] == '0) ||
                           (tag_ff[15:8] == '0) || (tag_ff[7:0] == '0);
      stat.room          = (CMP_W'(count_ff) + CMP_W'(1) < CMP_W'(total_ff)) &&
                           (count_ff < CNT_W'(MAX_ENTRIES));
      stat.hit           = pend_ff && (rd_data[TAG_W-1:0] == tag_ff);
      stat.scan_done     = !pend_ff && !more;
      stat.rsp_free      = !rsp_valid_ff || rsp_tready;
      stat.entry_count   = count_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W-TAG_W-2)'(0), rsp_data_ff, rsp_st_ff};

endmodule

>>> sv/tvjt_ctrl.sv
// Controller state machine of the tag/value table: decode, slot read, scan, shift, respond.
// Uses tvjt_pkg; drives the datapath only through cmd_type / stat_type.
module tvjt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  tvjt_pkg::stat_type stat,
   output tvjt_pkg::cmd_type  cmd
);
   import tvjt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SLOT   = 3'd2;
   localparam logic [2:0] S_SEARCH = 3'd3;
   localparam logic [2:0] S_SHIFT  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.res_code = RES_OK_ZERO;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.res_load = 1'b1;
            state_in     = S_DONE;
            unique case (stat.opcode)
               OP_GET: begin
                  priority if (stat.tag_zero) begin
                     cmd.res_code = RES_TOTAL;
                  end else if (stat.tag_high_zero) begin
                     priority if (stat.slot_bad) begin
                        cmd.res_code = RES_INVALID;
                     end else if (stat.slot_in) begin
                        // slot address is on the RAM read port this cycle
                        cmd.res_load = 1'b0;
                        state_in     = S_SLOT;
                     end else begin
                        cmd.res_code = RES_OK_ZERO;
                     end
                  end else begin
                     cmd.res_load   = 1'b0;
                     cmd.scan_start = 1'b1;
                     state_in       = S_SEARCH;
                  end
               end
               OP_SET: begin
                  if (stat.zero_byte) begin
                     cmd.res_code = RES_INVALID;
                  end else begin
                     cmd.res_load   = 1'b0;
                     cmd.scan_start = 1'b1;
                     state_in       = S_SEARCH;
                  end
               end
               OP_DEL: begin
                  if (stat.tag_zero) begin
                     cmd.res_code = RES_INVALID;
                  end else begin
                     cmd.res_load   = 1'b0;
                     cmd.scan_start = 1'b1;
                     state_in       = S_SEARCH;
                  end
               end
               default: cmd.res_code = RES_INVALID;
            endcase
         end
         S_SLOT: begin
            cmd.res_load = 1'b1;
            cmd.res_code = RES_SLOT_TAG;
            state_in     = S_DONE;
         end
         S_SEARCH: begin
            priority if (stat.hit) begin
               cmd.res_load = 1'b1;
               state_in     = S_DONE;
               unique case (stat.opcode)
                  OP_GET: cmd.res_code = RES_VALUE;
                  OP_SET: begin
                     cmd.hit_write = 1'b1;
                     cmd.res_code  = RES_OK_ZERO;
                  end
                  OP_DEL: begin
                     cmd.res_load    = 1'b0;
                     cmd.shift_start = 1'b1;
                     state_in        = S_SHIFT;
                  end
                  default: cmd.res_code = RES_INVALID;
               endcase
            end else if (stat.scan_done) begin
               cmd.res_load = 1'b1;
               state_in     = S_DONE;
               unique case (stat.opcode)
                  OP_GET: cmd.res_code = RES_NOTFOUND;
                  OP_SET: begin
                     if (stat.room) begin
                        cmd.append   = 1'b1;
                        cmd.res_code = RES_OK_ZERO;
                     end else begin
                        cmd.res_code = RES_FULL;
                     end
                  end
                  default: cmd.res_code = RES_INVALID;
               endcase
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SHIFT: begin
            if (stat.scan_done) begin
               cmd.count_dec = 1'b1;
               cmd.res_load  = 1'b1;
               cmd.res_code  = RES_OK_ZERO;
               state_in      = S_DONE;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_push = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tag_value_jar_table_top: directed and random
// get/set/delete traffic scored against an in-bench table predictor.
// Depends on tvjt_pkg and the RTL of the tag/value table.
module tb;
   import tvjt_pkg::*;

   localparam logic [1:0] OP_BAD      = 2'd3;   // undefined opcode
   localparam int         POOL_SIZE   = 150;
   localparam int         QUIET_LIMIT = 5000;
   localparam int         NUM_PHASES  = 7;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] tag;
      logic [31:0] value;
   } table_request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data;
   } table_reply_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;    // opcode[1:0], tag[33:2], value[65:34]
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;    // status[1:0], data[33:2]
   logic                 csr_tvalid;
   logic                 csr_tready;
   logic [TOTAL_W-1:0]   csr_tdata;    // total_slots[7:0]

   // predictor state
   logic [31:0]          stored_tags   [MAX_ENTRIES];
   logic [31:0]          stored_values [MAX_ENTRIES];
   int                   fill_level = 0;
   int                   peak_fill = 0;
   logic [TOTAL_W-1:0]   slot_total;

   table_request_type    pending_requests [$];
   table_reply_type      expected_replies [$];
   table_request_type    offered;
   table_reply_type      got_reply;
   table_reply_type      want_reply;
   logic [31:0]          tag_pool [POOL_SIZE];
   int                   pool_cursor;

   int                   requests_taken = 0;
   int                   replies_checked = 0;
   int                   mismatches = 0;
   int                   status_count [4] = '{0, 0, 0, 0};
   int                   quiet_cycles = 0;
   int                   hold_left = 0;
   bit                   held_once = 1'b0;
   bit                   calm;

   int phase_slots [NUM_PHASES] = '{129, 255, 0, 64, 2, 200, 129};
   int phase_items [NUM_PHASES] = '{260, 80, 50, 120, 80, 120, 80};
   int phase_set   [NUM_PHASES] = '{70, 40, 40, 20, 45, 50, 30};
   int phase_del   [NUM_PHASES] = '{10, 30, 30, 60, 35, 25, 30};

   tag_value_jar_table_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic int find_entry(input logic [31:0] tag);
      for (int i = 0; i < fill_level; i++) begin
         if (stored_tags[i] == tag) return i;
      end
      return -1;
   endfunction

   // Applies one request to the predicted table and returns its reply.
   function automatic table_reply_type apply_request(input table_request_type rq);
      table_reply_type rp;
      int              pos;
      rp.status = ST_OK;
      rp.data   = '0;
      pos = find_entry(rq.tag);
      case (rq.opcode)
         OP_GET: begin
            if (rq.tag == 0) begin
               rp.data = {24'h0, slot_total};
            end else if (rq.tag[31:16] == 16'h0) begin
               // 1-based slot read; the slot just past the end reads as zero
               if (int'(rq.tag) > fill_level + 1) rp.status = ST_INVALID;
               else if (int'(rq.tag) <= fill_level) rp.data = stored_tags[rq.tag - 1];
            end else if (pos >= 0) begin
               rp.data = stored_values[pos];
            end else begin
               rp.status = ST_NOTFOUND;
            end
         end
         OP_SET: begin
            if (rq.tag[31:24] == 0 || rq.tag[23:16] == 0 ||
                rq.tag[15:8] == 0 || rq.tag[7:0] == 0) begin
               rp.status = ST_INVALID;
            end else if (pos >= 0) begin
               stored_values[pos] = rq.value;
            end else if (fill_level + 1 < int'(slot_total) && fill_level < MAX_ENTRIES) begin
               stored_tags[fill_level]   = rq.tag;
               stored_values[fill_level] = rq.value;
               fill_level++;
               if (fill_level > peak_fill) peak_fill = fill_level;
            end else begin
               rp.status = ST_FULL;
            end
         end
         OP_DEL: begin
            if (rq.tag != 0 && pos >= 0) begin
               for (int i = pos; i + 1 < fill_level; i++) begin
                  stored_tags[i]   = stored_tags[i + 1];
                  stored_values[i] = stored_values[i + 1];
               end
               fill_level--;
            end else begin
               rp.status = ST_INVALID;
            end
         end
         default: rp.status = ST_INVALID;
      endcase
      return rp;
   endfunction

   task automatic queue_request(input logic [1:0] op, input logic [31:0] tag,
                                input logic [31:0] value);
      table_request_type rq;
      rq.opcode = op;
      rq.tag    = tag;
      rq.value  = value;
      pending_requests.push_back(rq);
   endtask

   // Random request; sequential pool walk on sets fills the table quickly.
   task automatic queue_random(input int set_pct, input int del_pct, input bit walk);
      logic [1:0]  op;
      logic [31:0] tag;
      int          r;
      int          t;
      r = $urandom_range(0, 99);
      if (r < set_pct) op = OP_SET;
      else if (r < set_pct + del_pct) op = OP_DEL;
      else if (r < 98) op = OP_GET;
      else op = OP_BAD;
      t = $urandom_range(0, 99);
      if (t < 75) begin
         if (walk && op == OP_SET) begin
            tag = tag_pool[pool_cursor];
            pool_cursor = (pool_cursor + 1) % POOL_SIZE;
         end else begin
            tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
         end
      end else if (t < 85) begin
         tag = $urandom_range(1, MAX_ENTRIES + 4);
      end else if (t < 90) begin
         tag = {16'h0, 16'($urandom())};
      end else if (t < 95) begin
         tag = $urandom();
      end else if (t < 98) begin
         tag = $urandom();
         tag[8 * $urandom_range(0, 3) +: 8] = 8'h0;
      end else begin
         tag = '0;
      end
      queue_request(op, tag, $urandom());
   endtask

   task automatic program_slot_total(input logic [TOTAL_W-1:0] v);
      @(posedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= v;
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid <= 1'b0;
      slot_total = v;
   endtask

   // Sender stays quiet until every queued item has been answered.
   task automatic wait_for_drain();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_replies.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(apply_request(offered));
            requests_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
               offered = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_W - 66){1'b0}}, offered.value, offered.tag, offered.opcode};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // reply monitor and receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_reply.status = rsp_tdata[1:0];
            got_reply.data   = rsp_tdata[33:2];
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected item, status %0d data %h",
                        $time, got_reply.status, got_reply.data);
               mismatches++;
            end else begin
               want_reply = expected_replies.pop_front();
               if (got_reply.status !== want_reply.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want_reply.status, got_reply.status);
                  mismatches++;
               end
               if (got_reply.data !== want_reply.data) begin
                  $display("%0t: data expected %h actual %h", $time,
                           want_reply.data, got_reply.data);
                  mismatches++;
               end
               status_count[want_reply.status]++;
            end
            replies_checked++;
         end
         // one long hold-off so the block backs up into its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held_once && replies_checked >= 150) begin
            held_once = 1'b1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || $urandom_range(0, 99) >= 22;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_tvalid && csr_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d items outstanding",
                     $time, QUIET_LIMIT, expected_replies.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset      = 1'b1;
      csr_tvalid = 1'b0;
      csr_tdata  = '0;
      slot_total = TOTAL_RESET;
      pool_cursor = 0;
      calm = 1'b0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         tag_pool[i] = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                        8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, slot reads, bad tags, update, shift on delete
      queue_request(OP_GET, 32'h0, 32'h0);
      queue_request(OP_GET, 32'd1, 32'h0);
      queue_request(OP_GET, 32'd2, 32'h0);
      queue_request(OP_GET, 32'h0000_FFFF, 32'hFFFF_FFFF);
      queue_request(OP_SET, 32'h0011_2233, 32'h1);
      queue_request(OP_SET, 32'h1122_3300, 32'h2);
      queue_request(OP_SET, 32'h0102_0304, 32'hFFFF_FFFF);
      queue_request(OP_SET, 32'hFFFF_FFFF, 32'h0);
      queue_request(OP_SET, 32'h8080_8080, 32'h1234_5678);
      queue_request(OP_SET, 32'h0102_0304, 32'hA5A5_A5A5);
      queue_request(OP_GET, 32'h0102_0304, 32'h0);
      queue_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
      queue_request(OP_GET, 32'd1, 32'h0);
      queue_request(OP_GET, 32'd3, 32'h0);
      queue_request(OP_GET, 32'd4, 32'h0);
      queue_request(OP_GET, 32'd5, 32'h0);
      queue_request(OP_GET, 32'hDEAD_BEEF, 32'h0);
      queue_request(OP_GET, 32'h0001_0000, 32'h0);
      queue_request(OP_DEL, 32'h0, 32'h0);
      queue_request(OP_DEL, 32'h1200_3456, 32'h0);
      queue_request(OP_DEL, 32'hAABB_CCDD, 32'h0);
      queue_request(OP_DEL, 32'h0102_0304, 32'h0);
      queue_request(OP_GET, 32'd1, 32'h0);
      queue_request(OP_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(OP_GET, 32'h8080_8080, 32'h0);
      wait_for_drain();

      // register lowered below the fill level: appends refused, rest works
      program_slot_total(8'd1);
      queue_request(OP_SET, 32'h0A0B_0C0D, 32'h5);
      queue_request(OP_SET, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
      queue_request(OP_GET, 32'h0, 32'h0);
      queue_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
      queue_request(OP_DEL, 32'h8080_8080, 32'h0);
      wait_for_drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         program_slot_total(TOTAL_W'(phase_slots[p]));
         calm = (p == 5);
         for (int n = 0; n < phase_items[p]; n++) begin
            queue_random(phase_set[p], phase_del[p], p == 0);
         end
         wait_for_drain();
      end
      calm = 1'b0;

      repeat (20) @(posedge clock);
      $display("%0d requests, %0d replies over %0d slot-total settings, peak fill %0d",
               requests_taken, replies_checked, NUM_PHASES + 2, peak_fill);
      $display("replies by status: ok %0d, invalid %0d, not found %0d, full %0d",
               status_count[ST_OK], status_count[ST_INVALID],
               status_count[ST_NOTFOUND], status_count[ST_FULL]);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
